### src/rslj_pkg.sv
// ----------------------------------------------------------------------------
// rslj_pkg
// Shared types and constants for the RTP stream lock and jitter block.
// ----------------------------------------------------------------------------
`default_nettype none

package rslj_pkg;

  // input stream payload layout (s_tdata)
  localparam int unsigned IN_DATA_W  = 144;
  localparam int unsigned OUT_DATA_W = 144;

  // configuration port
  localparam int unsigned CFG_ADDR_W = 3;
  localparam int unsigned CFG_DATA_W = 32;
  localparam logic        REG_LOCAL_ADDRESS = 1'b0;  // word index of local_address

  // record queue between front and back
  localparam int unsigned QDEPTH = 4;
  localparam int unsigned QAW    = $clog2(QDEPTH);
  localparam int unsigned QCW    = $clog2(QDEPTH + 1);

  // jitter arithmetic
  localparam int unsigned JIT_W        = 31;
  localparam logic [31:0] TS_TO_US     = 32'd1000;  // 16 kHz tick group to microseconds
  localparam int unsigned TS_SHIFT     = 4;         // timestamp divided by 16
  localparam int unsigned JIT_SHIFT    = 4;         // smoothing gain 1/16
  localparam logic [JIT_W-1:0] JIT_MAX = {JIT_W{1'b1}};

  // one record, classified by the front and carried out by the back
  typedef struct packed {
    logic        is_incoming;
    logic [15:0] sequence_req;
    logic [31:0] media_time;
    logic [31:0] arrival_us;
    logic [31:0] stream_id;
  } rec_t;

endpackage

`default_nettype wire

### src/rslj_front.sv
// ----------------------------------------------------------------------------
// rslj_front
// Accepts packet headers, sorts them by direction, tracks the stream lock of
// each direction and pushes records of locked streams into the queue.
// ----------------------------------------------------------------------------
`default_nettype none

module rslj_front (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic [31:0] local_address,
  input  wire logic        in_accept,
  input  wire logic [31:0] source_address,
  input  wire logic        marker,
  input  wire logic [31:0] media_time,
  input  wire logic [31:0] stream_id,
  input  wire logic [15:0] sequence_req,
  input  wire logic [31:0] arrival_us,
  output rslj_pkg::rec_t   push_rec,
  output logic             push
);

  logic        out_locked;
  logic [31:0] out_stream;
  logic        in_locked;
  logic [31:0] in_stream;

  logic start_pkt;
  logic incoming;
  logic lock_now;
  logic match;

  always_comb begin
    start_pkt = marker && (media_time == 32'd0);
    incoming  = (source_address != local_address);
    if (incoming) begin
      lock_now = !in_locked && start_pkt;
      match    = lock_now || (in_locked && (stream_id == in_stream));
    end else begin
      lock_now = !out_locked && start_pkt;
      match    = lock_now || (out_locked && (stream_id == out_stream));
    end
  end

  assign push = in_accept && match;

  always_comb begin
    push_rec.is_incoming  = incoming;
    push_rec.sequence_req = sequence_req;
    push_rec.media_time   = media_time;
    push_rec.arrival_us   = arrival_us;
    push_rec.stream_id    = stream_id;
  end

  // lock is taken once per direction and never moved
  always_ff @(posedge clk) begin
    if (rst) begin
      out_locked <= 1'b0;
      out_stream <= 32'd0;
      in_locked  <= 1'b0;
      in_stream  <= 32'd0;
    end else if (in_accept && lock_now) begin
      if (incoming) begin
        in_locked <= 1'b1;
        in_stream <= stream_id;
      end else begin
        out_locked <= 1'b1;
        out_stream <= stream_id;
      end
    end
  end

endmodule

`default_nettype wire

### src/rslj_queue.sv
// ----------------------------------------------------------------------------
// rslj_queue
// Short register queue of records between the front and the back.
// ----------------------------------------------------------------------------
`default_nettype none

module rslj_queue (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          push,
  input  wire rslj_pkg::rec_t push_rec,
  input  wire logic          pop,
  output rslj_pkg::rec_t     head_rec,
  output logic               full,
  output logic               empty
);

  rslj_pkg::rec_t entries [rslj_pkg::QDEPTH];

  logic [rslj_pkg::QAW-1:0] wr_ptr;
  logic [rslj_pkg::QAW-1:0] rd_ptr;
  logic [rslj_pkg::QCW-1:0] count;

  assign full     = (count == rslj_pkg::QCW'(rslj_pkg::QDEPTH));
  assign empty    = (count == '0);
  assign head_rec = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_rec;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

### src/rslj_back.sv
// ----------------------------------------------------------------------------
// rslj_back
// Three-stage jitter pipeline: differences, deviation, filter update and
// output register. All stages advance together when the output can move.
// ----------------------------------------------------------------------------
`default_nettype none

module rslj_back (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire rslj_pkg::rec_t              head_rec,
  input  wire logic                        empty,
  output logic                             pop,
  output logic                             out_valid,
  input  wire logic                        out_ready,
  output rslj_pkg::rec_t                   out_rec,
  output logic [rslj_pkg::JIT_W-1:0]       out_jitter
);

  logic adv;

  // previous incoming record of the locked stream
  logic        prev_valid;
  logic [31:0] prev_media_time;
  logic [31:0] prev_arrival;

  logic [rslj_pkg::JIT_W-1:0] jitter_acc;

  // stage 1
  logic           v1;
  rslj_pkg::rec_t rec1;
  logic           upd1;
  logic [31:0]    a1;
  logic [31:0]    tq1;

  // stage 2
  logic           v2;
  rslj_pkg::rec_t rec2;
  logic           upd2;
  logic [31:0]    d2;

  logic [31:0] a_in;
  logic [31:0] tdiff;
  logic [31:0] tq_in;
  logic [31:0] t_us;
  logic [31:0] dev;
  logic [31:0] d_in;
  logic [32:0] j_sum;
  logic [rslj_pkg::JIT_W-1:0] j_next;

  assign adv = !out_valid || out_ready;
  assign pop = adv && !empty;

  always_comb begin
    a_in  = head_rec.arrival_us - prev_arrival;
    tdiff = head_rec.media_time - prev_media_time;
    // divide by 16 toward zero: bias negatives before the arithmetic shift
    tq_in = 32'($signed(tdiff + (tdiff[31] ? 32'd15 : 32'd0)) >>> rslj_pkg::TS_SHIFT);
  end

  always_comb begin
    t_us = 32'(tq1 * rslj_pkg::TS_TO_US);
    dev  = a1 - t_us;
    d_in = dev[31] ? (32'd0 - dev) : dev;
  end

  always_comb begin
    j_sum = {2'b00, jitter_acc} + {1'b0, d2}
            - {2'b00, (jitter_acc >> rslj_pkg::JIT_SHIFT)};
    j_next = (j_sum[32:31] != 2'b00) ? rslj_pkg::JIT_MAX : j_sum[rslj_pkg::JIT_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1         <= 1'b0;
      v2         <= 1'b0;
      out_valid  <= 1'b0;
      prev_valid <= 1'b0;
      jitter_acc <= '0;
    end else if (adv) begin
      v1        <= pop;
      v2        <= v1;
      out_valid <= v2;
      if (pop && head_rec.is_incoming) begin
        prev_valid <= 1'b1;
      end
      if (v2 && upd2) begin
        jitter_acc <= j_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      rec1 <= head_rec;
      upd1 <= head_rec.is_incoming && prev_valid;
      a1   <= a_in;
      tq1  <= tq_in;
      rec2 <= rec1;
      upd2 <= upd1;
      d2   <= d_in;
      out_rec    <= rec2;
      out_jitter <= (v2 && upd2) ? j_next : jitter_acc;
      if (pop && head_rec.is_incoming) begin
        prev_media_time <= head_rec.media_time;
        prev_arrival    <= head_rec.arrival_us;
      end
    end
  end

endmodule

`default_nettype wire

### src/rtp_stream_lock_jitter.sv
// ----------------------------------------------------------------------------
// rtp_stream_lock_jitter
// Locks onto one RTP stream per direction and emits a record per packet of
// the locked streams, with the smoothed interarrival jitter of incoming ones.
// ----------------------------------------------------------------------------
//  port group  role             payload
//  s_*         header in        tdata: src, media_time, stream_id, seq, arrival
//                               tuser: marker
//  m_*         record out       tdata: seq, media_time, arrival, stream_id, jitter
//                               tuser: is_incoming
//  p*          register access  local_address at byte address 0
//
//  One header per cycle while the record queue is not full; a record passes
//  through that queue and then the difference, deviation and filter stages.
//  A four-entry record queue lets the input keep taking headers while the
//  output stalls; s_tready drops only when that queue is full.
//  Synchronous reset clears locks, jitter state, queue and pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

module rtp_stream_lock_jitter (
  input  wire logic                                 clk,
  input  wire logic                                 rst,
  // header in
  input  wire logic                                 s_tvalid,
  output logic                                      s_tready,
  // source_address[31:0], media_time[63:32], stream_id[95:64],
  // sequence_req[111:96], arrival_us[143:112]
  input  wire logic [rslj_pkg::IN_DATA_W-1:0]       s_tdata,
  // marker[0]
  input  wire logic                                 s_tuser,
  // record out
  output logic                                      m_tvalid,
  input  wire logic                                 m_tready,
  // rec_sequence[15:0], rec_media_time[47:16], rec_arrival_us[79:48],
  // rec_stream_id[111:80], jitter_scaled[142:112], zero[143]
  output logic [rslj_pkg::OUT_DATA_W-1:0]           m_tdata,
  // is_incoming[0]
  output logic                                      m_tuser,
  // register access
  input  wire logic                                 psel,
  input  wire logic                                 penable,
  input  wire logic                                 pwrite,
  input  wire logic [rslj_pkg::CFG_ADDR_W-1:0]      paddr,
  input  wire logic [rslj_pkg::CFG_DATA_W-1:0]      pwdata,
  output logic [rslj_pkg::CFG_DATA_W-1:0]           prdata,
  output logic                                      pready
);

  logic [31:0] local_address;

  logic           in_accept;
  logic           q_push;
  logic           q_pop;
  logic           q_full;
  logic           q_empty;
  rslj_pkg::rec_t push_rec;
  rslj_pkg::rec_t head_rec;
  rslj_pkg::rec_t out_rec;
  logic [rslj_pkg::JIT_W-1:0] out_jitter;

  // configuration
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      local_address <= 32'd0;
    end else if (psel && penable && pwrite && pready
                 && paddr[2] == rslj_pkg::REG_LOCAL_ADDRESS) begin
      local_address <= pwdata;
    end
  end

  assign prdata = (paddr[2] == rslj_pkg::REG_LOCAL_ADDRESS) ? local_address : '0;

  assign s_tready  = !q_full;
  assign in_accept = s_tvalid && s_tready;

  rslj_front u_front (
    .clk            (clk),
    .rst            (rst),
    .local_address  (local_address),
    .in_accept      (in_accept),
    .source_address (s_tdata[31:0]),
    .marker         (s_tuser),
    .media_time     (s_tdata[63:32]),
    .stream_id      (s_tdata[95:64]),
    .sequence_req   (s_tdata[111:96]),
    .arrival_us     (s_tdata[143:112]),
    .push_rec       (push_rec),
    .push           (q_push)
  );

  rslj_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (q_push),
    .push_rec (push_rec),
    .pop      (q_pop),
    .head_rec (head_rec),
    .full     (q_full),
    .empty    (q_empty)
  );

  rslj_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head_rec   (head_rec),
    .empty      (q_empty),
    .pop        (q_pop),
    .out_valid  (m_tvalid),
    .out_ready  (m_tready),
    .out_rec    (out_rec),
    .out_jitter (out_jitter)
  );

  assign m_tuser = out_rec.is_incoming;
  assign m_tdata = {1'b0, out_jitter, out_rec.stream_id, out_rec.arrival_us,
                    out_rec.media_time, out_rec.sequence_req};

  // never push a record into a full queue
  assert property (@(posedge clk) disable iff (rst) q_push |-> !q_full)
    else $error("record pushed into full queue");

  // never pop an empty queue
  assert property (@(posedge clk) disable iff (rst) q_pop |-> !q_empty)
    else $error("record popped from empty queue");

  // reset flushes the output stage
  assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("output valid right after reset");

  // a held record keeps its jitter value while stalled
  assert property (@(posedge clk) disable iff (rst)
                   (m_tvalid && !m_tready) |=> (m_tvalid && $stable(out_jitter)))
    else $error("stalled record lost its jitter value");

endmodule

`default_nettype wire
